// ===== sv/fca_pkg.sv =====
// shared constants, codes and control types of the block allocation table
`default_nettype none

package fca_pkg;

  localparam int BLOCKS_DEF = 1024;
  localparam int LINKS_DEF  = 512;
  localparam int END_DEF    = 0;
  localparam int FREE_DEF   = 65535;

  localparam int ACT_W  = 2;
  localparam int BLK_W  = 10;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 10;
  localparam int LINK_W = 16;

  localparam logic [ACT_W-1:0] ACT_FORMAT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FOLLOW = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BROKEN = 2'd2;

  localparam logic [1:0] IDX_ZERO  = 2'd0;
  localparam logic [1:0] IDX_ROOT  = 2'd1;
  localparam logic [1:0] IDX_FOUND = 2'd2;

  typedef struct packed {
    logic              load;
    logic              fmt_wr;
    logic              find_go;
    logic              rd_cur;
    logic              wr_free;
    logic              res_en;
    logic [STAT_W-1:0] res_status;
    logic [1:0]        res_idx;
    logic              res_link;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic blk_ok;
    logic fhit;
    logic flast;
    logic rd_end;
    logic rd_free;
    logic rd_out;
    logic steps_full;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/fat_chain_allocator.sv =====
// block allocation table: busy while an action runs, one result per transaction
// format sweeps every entry; find-free scans upward and stops at the lowest free block,
// free-chain reads then frees each link walked, up to BLOCKS links, follow reads one entry,
// and an out-of-range start block for free-chain or follow is answered without leaving idle
// one transaction at a time; the link table memory has a single read and a single write port
// reset runs the format sweep over all BLOCKS entries with busy high and no result strobe
// done marks each result for one cycle; the receiver cannot stall
`default_nettype none

module fat_chain_allocator #(
  parameter int BLOCKS          = fca_pkg::BLOCKS_DEF,
  parameter int LINKS_PER_BLOCK = fca_pkg::LINKS_DEF,
  parameter int END_MARK        = fca_pkg::END_DEF,
  parameter int FREE_MARK       = fca_pkg::FREE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [fca_pkg::ACT_W-1:0]   action,
  input  wire logic [fca_pkg::BLK_W-1:0]   block,
  output logic                             done,
  output logic [fca_pkg::STAT_W-1:0]       status,
  output logic [fca_pkg::IDX_W-1:0]        index,
  output logic [fca_pkg::LINK_W-1:0]       link_value,
  output logic                             at_end
);
  import fca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  fca_dp #(
    .BLOCKS          (BLOCKS),
    .LINKS_PER_BLOCK (LINKS_PER_BLOCK),
    .END_MARK        (END_MARK),
    .FREE_MARK       (FREE_MARK)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .block      (block),
    .cmd        (cmd),
    .sts        (sts),
    .done       (done),
    .status     (status),
    .index      (index),
    .link_value (link_value),
    .at_end     (at_end)
  );

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fmt_wr && cmd.wr_free))
    else $error("two writers on the link table");
  a_one_read: assert property (@(posedge clk) disable iff (rst)
    !(cmd.find_go && cmd.rd_cur))
    else $error("two readers on the link table");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NOFREE || status == ST_BROKEN))
    else $error("undefined status code");
  a_reset_sweep: assert property (@(posedge clk) $fell(rst) |-> (busy && !done))
    else $error("format sweep not running after reset");
`endif

endmodule

`default_nettype wire

// ===== sv/fca_dp.sv =====
// datapath: link table memory, sweep counter, chain walker and result registers
`default_nettype none

module fca_dp #(
  parameter int BLOCKS          = fca_pkg::BLOCKS_DEF,
  parameter int LINKS_PER_BLOCK = fca_pkg::LINKS_DEF,
  parameter int END_MARK        = fca_pkg::END_DEF,
  parameter int FREE_MARK       = fca_pkg::FREE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [fca_pkg::BLK_W-1:0]   block,
  input  wire fca_pkg::cmd_t               cmd,
  output fca_pkg::sts_t                    sts,
  output logic                             done,
  output logic [fca_pkg::STAT_W-1:0]       status,
  output logic [fca_pkg::IDX_W-1:0]        index,
  output logic [fca_pkg::LINK_W-1:0]       link_value,
  output logic                             at_end
);
  import fca_pkg::*;

  localparam int AW   = $clog2(BLOCKS);
  localparam int NFAT = (BLOCKS + LINKS_PER_BLOCK - 1) / LINKS_PER_BLOCK;

  localparam logic [AW-1:0]     LAST_A   = AW'(BLOCKS - 1);
  localparam logic [AW-1:0]     NFAT_A   = AW'(NFAT);
  localparam logic [AW-1:0]     ROOT_A   = AW'(NFAT + 1);
  localparam logic [AW:0]       BLOCKS_S = (AW+1)'(BLOCKS);
  localparam logic [LINK_W:0]   BLOCKS_L = (LINK_W+1)'(BLOCKS);
  localparam logic [LINK_W-1:0] EMARK    = LINK_W'(END_MARK);
  localparam logic [LINK_W-1:0] FMARK    = LINK_W'(FREE_MARK);
  localparam logic [IDX_W-1:0]  ROOT_IDX = IDX_W'(NFAT + 1);

  logic [LINK_W-1:0] mem [BLOCKS];
  logic [LINK_W-1:0] rdata;
  logic [AW-1:0]     cnt;
  logic              fdone;
  logic              fvld;
  logic [AW-1:0]     faddr;
  logic [AW-1:0]     cur;
  logic [AW:0]       steps;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [LINK_W-1:0] wdata;
  logic [LINK_W-1:0] lay_word;
  logic [31:0]       blk32;
  logic [31:0]       faddr32;
  logic              find_rd;

  assign blk32   = {22'd0, block};
  assign faddr32 = 32'(faddr);
  assign find_rd = cmd.find_go && !fdone;

  // formatted layout word for the entry at the sweep counter
  always_comb begin
    if (cnt == '0) begin
      lay_word = EMARK;
    end else if (cnt < NFAT_A) begin
      lay_word = LINK_W'(32'(cnt) + 32'd1);
    end else if (cnt == NFAT_A || cnt == ROOT_A) begin
      lay_word = EMARK;
    end else begin
      lay_word = FMARK;
    end
  end

  assign re    = find_rd || cmd.rd_cur;
  assign raddr = cmd.rd_cur ? cur : cnt;
  assign we    = cmd.fmt_wr || cmd.wr_free;
  assign waddr = cmd.fmt_wr ? cnt : cur;
  assign wdata = cmd.fmt_wr ? lay_word : FMARK;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign sts.cnt_last   = (cnt == LAST_A);
  assign sts.blk_ok     = (blk32 < 32'(BLOCKS));
  assign sts.rd_end     = (rdata == EMARK);
  assign sts.rd_free    = (rdata == FMARK);
  assign sts.rd_out     = ({1'b0, rdata} >= BLOCKS_L);
  assign sts.steps_full = (steps == BLOCKS_S);
  assign sts.fhit       = fvld && (rdata == FMARK);
  assign sts.flast      = fvld && (faddr == LAST_A);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      fdone <= 1'b0;
      fvld  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.res_en;
      if (cmd.load) begin
        cnt   <= '0;
        fdone <= 1'b0;
        fvld  <= 1'b0;
      end else if (cmd.fmt_wr) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.find_go) begin
        if (!fdone) begin
          cnt  <= cnt + 1'b1;
          fvld <= 1'b1;
          if (cnt == LAST_A) begin
            fdone <= 1'b1;
          end
        end else begin
          fvld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= AW'(blk32);
      steps <= '0;
    end else if (cmd.wr_free) begin
      cur   <= rdata[AW-1:0];
      steps <= steps + 1'b1;
    end
    if (find_rd) begin
      faddr <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      status     <= cmd.res_status;
      link_value <= cmd.res_link ? rdata : '0;
      at_end     <= cmd.res_link && (rdata == EMARK);
      case (cmd.res_idx)
        IDX_ROOT:  index <= ROOT_IDX;
        IDX_FOUND: index <= faddr32[IDX_W-1:0];
        default:   index <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/fca_ctrl.sv =====
// controller state machine for format, find-free, free-chain and follow
`default_nettype none

module fca_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fca_pkg::ACT_W-1:0]  action,
  input  wire fca_pkg::sts_t              sts,
  output fca_pkg::cmd_t                   cmd,
  output logic                            busy
);
  import fca_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FMT     = 3'd1;
  localparam logic [2:0] S_FIND    = 3'd2;
  localparam logic [2:0] S_CH_RD   = 3'd3;
  localparam logic [2:0] S_CH_WR   = 3'd4;
  localparam logic [2:0] S_FOL_RD  = 3'd5;
  localparam logic [2:0] S_FOL_RES = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       report;
  logic       report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_FMT;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    report_next = report;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (action)
            ACT_FORMAT: begin
              state_next  = S_FMT;
              report_next = 1'b1;
            end
            ACT_FIND: begin
              state_next = S_FIND;
            end
            ACT_FREE: begin
              if (sts.blk_ok) begin
                state_next = S_CH_RD;
              end else begin
                cmd.res_en     = 1'b1;
                cmd.res_status = ST_BROKEN;
              end
            end
            ACT_FOLLOW: begin
              if (sts.blk_ok) begin
                state_next = S_FOL_RD;
              end else begin
                cmd.res_en     = 1'b1;
                cmd.res_status = ST_BROKEN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FMT: begin
        cmd.fmt_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_IDLE;
          if (report) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_idx    = IDX_ROOT;
          end
        end
      end
      S_FIND: begin
        cmd.find_go = 1'b1;
        if (sts.fhit) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_idx    = IDX_FOUND;
          state_next     = S_IDLE;
        end else if (sts.flast) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_NOFREE;
          state_next     = S_IDLE;
        end
      end
      S_CH_RD: begin
        if (sts.steps_full) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_BROKEN;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_CH_WR;
        end
      end
      S_CH_WR: begin
        if (sts.rd_end) begin
          cmd.wr_free    = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_IDLE;
        end else if (sts.rd_free) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_BROKEN;
          state_next     = S_IDLE;
        end else begin
          cmd.wr_free = 1'b1;
          if (sts.rd_out) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ST_BROKEN;
            state_next     = S_IDLE;
          end else begin
            state_next = S_CH_RD;
          end
        end
      end
      S_FOL_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_FOL_RES;
      end
      S_FOL_RES: begin
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_link   = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the fat_chain_allocator link table block
`timescale 1ns / 100ps

module testbench;
  import fca_pkg::*;

  localparam int BLOCKS = BLOCKS_DEF;
  localparam int LINKS_PER_BLOCK = LINKS_DEF;
  localparam logic [LINK_W-1:0] END_WORD = END_DEF;
  localparam logic [LINK_W-1:0] FREE_WORD = FREE_DEF;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [LINK_W-1:0] link_value;
    logic              at_end;
  } reply_t;

  class link_table_model;
    logic [LINK_W-1:0] links [BLOCKS];
    reply_t pending_replies [$];
    int mismatch_count;

    function new();
      mismatch_count = 0;
      void'(lay_out_table());
    endfunction

    function int unsigned lay_out_table();
      int unsigned table_blocks;
      int unsigned i;
      table_blocks = (BLOCKS + LINKS_PER_BLOCK - 1) / LINKS_PER_BLOCK;
      for (i = 0; i < BLOCKS; i++) links[i] = FREE_WORD;
      links[0] = END_WORD;
      for (i = 1; i < table_blocks && i < BLOCKS; i++) links[i] = LINK_W'(i + 1);
      if (table_blocks < BLOCKS) links[table_blocks] = END_WORD;
      if (table_blocks + 1 < BLOCKS) links[table_blocks + 1] = END_WORD;
      return table_blocks + 1;
    endfunction

    function logic [STAT_W-1:0] release_chain(int unsigned first);
      int unsigned cur;
      int unsigned steps;
      logic [LINK_W-1:0] word;
      cur = first;
      if (cur >= BLOCKS) return ST_BROKEN;
      for (steps = 0; steps < BLOCKS; steps++) begin
        word = links[cur];
        if (word == END_WORD) begin
          links[cur] = FREE_WORD;
          return ST_OK;
        end
        if (word == FREE_WORD) return ST_BROKEN;
        links[cur] = FREE_WORD;
        if (word >= BLOCKS) return ST_BROKEN;
        cur = word;
      end
      return ST_BROKEN;
    endfunction

    function void accept_request(logic [ACT_W-1:0] act, logic [BLK_W-1:0] blk);
      reply_t r;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      case (act)
        ACT_FORMAT: begin
          r.index = IDX_W'(lay_out_table());
        end
        ACT_FIND: begin
          r.status = ST_NOFREE;
          for (i = 0; i < BLOCKS; i++) begin
            if (links[i] == FREE_WORD) begin
              r.status = ST_OK;
              r.index = IDX_W'(i);
              break;
            end
          end
        end
        ACT_FREE: begin
          r.status = release_chain(blk);
        end
        default: begin
          if (blk >= BLOCKS) begin
            r.status = ST_BROKEN;
          end else begin
            r.link_value = links[blk];
            r.at_end = (links[blk] == END_WORD);
          end
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transaction result %h", $time, got);
        mismatch_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatch_count++;
      end
      if (got.index !== want.index) begin
        $display("%0t: index expected %0d actual %0d", $time, want.index, got.index);
        mismatch_count++;
      end
      if (got.link_value !== want.link_value) begin
        $display("%0t: link_value expected %h actual %h", $time, want.link_value,
                 got.link_value);
        mismatch_count++;
      end
      if (got.at_end !== want.at_end) begin
        $display("%0t: at_end expected %0d actual %0d", $time, want.at_end, got.at_end);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ACT_W-1:0] action = ACT_FORMAT;
  logic [BLK_W-1:0] block = '0;
  logic busy;
  logic done;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0] index;
  logic [LINK_W-1:0] link_value;
  logic at_end;

  link_table_model model = new();

  fat_chain_allocator DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .block(block),
    .done(done),
    .status(status),
    .index(index),
    .link_value(link_value),
    .at_end(at_end)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) model.check_reply({status, index, link_value, at_end});
  end

  task automatic send(logic [ACT_W-1:0] act, logic [BLK_W-1:0] blk, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    action = act;
    block = blk;
    do @(posedge clk); while (busy);
    model.accept_request(act, blk);
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    start = 1'b0;
    while (model.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_transactions(int count, int idle_pct);
    logic [ACT_W-1:0] act;
    logic [BLK_W-1:0] blk;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 8) act = ACT_FORMAT;
      else if (r < 30) act = ACT_FIND;
      else if (r < 62) act = ACT_FREE;
      else act = ACT_FOLLOW;
      if ($urandom_range(99) < 70) blk = BLK_W'($urandom_range(6, 0));
      else blk = BLK_W'($urandom_range(2**BLK_W - 1, 0));
      send(act, blk, idle_pct);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // formatted layout after reset
    send(ACT_FOLLOW, 10'd0, 0);
    send(ACT_FOLLOW, 10'd1, 0);
    send(ACT_FOLLOW, 10'd2, 0);
    send(ACT_FOLLOW, 10'd3, 0);
    send(ACT_FOLLOW, 10'd4, 0);
    send(ACT_FOLLOW, 10'd1023, 0);
    send(ACT_FIND, 10'd0, 0);
    // free the table region chain, then hit an unused link
    send(ACT_FREE, 10'd1, 0);
    send(ACT_FOLLOW, 10'd1, 0);
    send(ACT_FIND, 10'd0, 0);
    send(ACT_FREE, 10'd1, 0);
    send(ACT_FREE, 10'd0, 0);
    send(ACT_FIND, 10'd0, 0);
    send(ACT_FREE, 10'd3, 0);
    send(ACT_FOLLOW, 10'd3, 0);
    send(ACT_FREE, 10'd1023, 0);
    // reformat a dirty table, then free a chain from its tail block before its head
    send(ACT_FORMAT, 10'd1023, 0);
    send(ACT_FREE, 10'd2, 0);
    send(ACT_FREE, 10'd1, 0);
    send(ACT_FOLLOW, 10'd1, 0);
    send(ACT_FORMAT, 10'd0, 0);
    send(ACT_FIND, 10'd1023, 0);
    wait_for_replies();

    random_transactions(PHASE_ITEMS, 0);
    wait_for_replies();
    random_transactions(PHASE_ITEMS, 46);
    wait_for_replies();
    random_transactions(PHASE_ITEMS, 0);
    wait_for_replies();
    random_transactions(PHASE_ITEMS, 14);
    wait_for_replies();

    repeat (20) @(posedge clk);
    if (model.mismatch_count == 0 && model.pending_replies.size() == 0) begin
      $display("fat_chain_allocator test passed");
    end else begin
      $display("fat_chain_allocator test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("fat_chain_allocator test failed");
    $finish;
  end

endmodule
